### rtl/kxc_pkg.sv
// Shared constants and types for the keyed XOR cipher with checksum.
// No dependencies; every other file in this block imports this package.
package kxc_pkg;

  localparam int MAX_KEY_BYTES = 48;
  localparam int KEY_WORDS     = 6;
  localparam int KEY_WORD_W    = 64;
  localparam int KEY_POS_W     = 6;
  localparam int DATA_W        = 8;
  localparam int HASH_W        = 32;
  localparam int HASH_SHIFT    = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = KEY_WORD_W;
  localparam int IN_TDATA_W    = DATA_W + HASH_W;
  localparam int OUT_TDATA_W   = DATA_W + HASH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 3'd0,
    CFG_KEY_LEN = 3'd1,
    CFG_KEY_W0  = 3'd2,
    CFG_KEY_W1  = 3'd3,
    CFG_KEY_W2  = 3'd4,
    CFG_KEY_W3  = 3'd5,
    CFG_KEY_W4  = 3'd6,
    CFG_KEY_W5  = 3'd7
  } cfg_idx_t;

  // Settings seen by the datapath. key_len is already clamped to 1..MAX_KEY_BYTES.
  typedef struct packed {
    logic                                  mode;
    logic [KEY_POS_W-1:0]                  key_len;
    logic [KEY_WORDS-1:0][KEY_WORD_W-1:0]  key_words;
  } kxc_cfg_t;

endpackage

### rtl/keyed_xor_cipher_with_checksum_unit.sv
// Keyed XOR cipher with times-33 checksum, top level. Takes one byte per cycle while
// the output is not stalled and returns its result in the cycle after acceptance; the
// hash and key position recurrence sets that rate. Configure only while no item is in flight.
// Depends on kxc_pkg, kxc_cfg_regs and kxc_datapath.
module keyed_xor_cipher_with_checksum_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kxc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kxc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kxc_pkg::IN_TDATA_W-1:0]   in_tdata,   // data_byte, expected_checksum
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kxc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // out_byte, running_hash
  output logic                             out_tlast,
  output logic                             out_tuser   // checksum_match
);
  import kxc_pkg::*;

  kxc_cfg_t          cfg;
  logic [DATA_W-1:0] res_byte;
  logic [HASH_W-1:0] res_hash;

  kxc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kxc_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_data_byte  (in_tdata[DATA_W-1:0]),
    .in_last       (in_tlast),
    .in_expected   (in_tdata[DATA_W +: HASH_W]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data_byte (res_byte),
    .out_hash      (res_hash),
    .out_last      (out_tlast),
    .out_match     (out_tuser)
  );

  assign out_tdata = {res_hash, res_byte};

endmodule

### rtl/kxc_cfg_regs.sv
// Configuration register file: mode, clamped key length and the six key words.
// Depends on kxc_pkg.
module kxc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kxc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kxc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output kxc_pkg::kxc_cfg_t               cfg
);
  import kxc_pkg::*;

  kxc_cfg_t             cfg_r;
  kxc_cfg_t             cfg_nxt;
  logic [KEY_POS_W-1:0] len_raw;
  logic [KEY_POS_W-1:0] len_clamped;

  assign len_raw = cfg_wdata[KEY_POS_W-1:0];

  // A zero length behaves as one; anything past the key store saturates.
  always_comb begin
    if (len_raw == '0) begin
      len_clamped = KEY_POS_W'(1);
    end else if (len_raw > KEY_POS_W'(MAX_KEY_BYTES)) begin
      len_clamped = KEY_POS_W'(MAX_KEY_BYTES);
    end else begin
      len_clamped = len_raw;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:    cfg_nxt.mode = cfg_wdata[0];
        CFG_KEY_LEN: cfg_nxt.key_len = len_clamped;
        CFG_KEY_W0:  cfg_nxt.key_words[0] = cfg_wdata;
        CFG_KEY_W1:  cfg_nxt.key_words[1] = cfg_wdata;
        CFG_KEY_W2:  cfg_nxt.key_words[2] = cfg_wdata;
        CFG_KEY_W3:  cfg_nxt.key_words[3] = cfg_wdata;
        CFG_KEY_W4:  cfg_nxt.key_words[4] = cfg_wdata;
        CFG_KEY_W5:  cfg_nxt.key_words[5] = cfg_wdata;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= 1'b0;
      cfg_r.key_len   <= KEY_POS_W'(1);
      cfg_r.key_words <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/kxc_datapath.sv
// Per-item datapath: key byte select, XOR, times-33 hash update, key position
// tracking and the result register. Depends on kxc_pkg.
module kxc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kxc_pkg::kxc_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kxc_pkg::DATA_W-1:0]    in_data_byte,
  input  logic                          in_last,
  input  logic [kxc_pkg::HASH_W-1:0]    in_expected,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kxc_pkg::DATA_W-1:0]    out_data_byte,
  output logic [kxc_pkg::HASH_W-1:0]    out_hash,
  output logic                          out_last,
  output logic                          out_match
);
  import kxc_pkg::*;

  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic [KEY_POS_W-1:0] pos_r, pos_nxt;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    byte_r;
  logic [HASH_W-1:0]    res_hash_r;
  logic                 last_r;
  logic                 match_r;

  logic                 in_fire;
  logic [KEY_POS_W-1:0] pos_use;
  logic [KEY_POS_W-1:0] pos_inc;
  logic [DATA_W-1:0]    key_byte;
  logic [DATA_W-1:0]    xor_byte;
  logic [DATA_W-1:0]    plain;
  logic [HASH_W-1:0]    hash_upd;
  logic                 match;

  // The result register frees up in the same cycle its item is taken.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // A position left beyond a shortened key restarts at the first key byte.
  assign pos_use  = (pos_r >= cfg.key_len) ? '0 : pos_r;
  assign key_byte = cfg.key_words[pos_use[KEY_POS_W-1:3]][{pos_use[2:0], 3'b000} +: DATA_W];
  assign xor_byte = in_data_byte ^ key_byte;
  assign plain    = cfg.mode ? xor_byte : in_data_byte;
  assign hash_upd = (hash_r << HASH_SHIFT) + hash_r
                  + {{(HASH_W-DATA_W){plain[DATA_W-1]}}, plain};
  assign match    = in_last && cfg.mode && (hash_upd == in_expected);
  assign pos_inc  = pos_use + KEY_POS_W'(1);

  always_comb begin
    hash_nxt = hash_r;
    pos_nxt  = pos_r;
    if (in_fire) begin
      if (in_last) begin
        hash_nxt = '0;
        pos_nxt  = '0;
      end else begin
        hash_nxt = hash_upd;
        pos_nxt  = (pos_inc >= cfg.key_len) ? '0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      pos_r  <= pos_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r     <= xor_byte;
      res_hash_r <= hash_upd;
      last_r     <= in_last;
      match_r    <= match;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = byte_r;
  assign out_hash      = res_hash_r;
  assign out_last      = last_r;
  assign out_match     = match_r;

`ifndef SYNTH
  a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < KEY_POS_W'(MAX_KEY_BYTES))
    else $error("key position ran past the key store");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |=> hash_r == '0 && pos_r == '0)
    else $error("hash or key position not cleared after the last item");

  a_match_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && match_r |-> last_r)
    else $error("checksum match flagged on an item that is not last");

  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item did not reach the result register");
`endif

endmodule
